>>> hw/rtl/dptk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptk_pkg
// Shared types and constants of the dot-product top-K search block.
// ----------------------------------------------------------------------------
package dptk_pkg;

  localparam int DEF_MAX_DIM      = 1024;
  localparam int DEF_MAX_MEMORIES = 65536;
  localparam int DEF_K_MAX        = 16;

  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 32;
  localparam int SCORE_W  = 42;
  localparam int INDEX_W  = 16;
  localparam int RANK_W   = 4;
  localparam int VLEN_W   = 11;
  localparam int RCNT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd512;
  localparam logic [RCNT_W-1:0] RCNT_RESET = 5'd5;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_COUNT  = 2'd1;

  // queue between the accumulate front and the ranking back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // one closed vector, as handed from front to back
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [INDEX_W-1:0]        index;
    logic                      scored;    // vector fit within capacity
    logic                      bank_end;  // emit the list after this one
    logic                      overflow;  // capacity was exceeded this pass
  } entry_t;

endpackage

>>> hw/rtl/dot_product_top_k_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_product_top_k_search
// Dot-product similarity search keeping the best K matches of a bank pass.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration transactions on cfg_* set vector_length (index 0) and
//   result_count (index 1); cfg_ready is always high.
//   s_* carries elements: tuser 0 loads the next query element, tuser 1
//   streams the next bank element; tlast marks the final bank element.
//   One element is taken per cycle while s_tready is high. Each closed
//   vector is scored by a three-stage read/multiply/accumulate path and
//   queued for ranking; the ranking side inserts one vector per cycle while
//   idle, so s_tready drops only when the four-entry queue is about to fill.
//   On tlast the ranking side streams result_count results (clamped to
//   1..K_MAX) on m_*, one per cycle, rank 0 first, m_tlast on the last. The
//   first result is registered once the tlast vector has passed the read and
//   multiply registers and the queue and the ranking side is emitting; a pass
//   end occupies the ranking side while it emits, and bank vectors queue up.
//   A stalled m_tready holds the current result; queued vectors wait.
//   rst clears all counters, the best list and pending results; the query
//   store keeps its contents and must be loaded before it is read.
// ----------------------------------------------------------------------------
module dot_product_top_k_search #(
  parameter int MAX_DIM      = dptk_pkg::DEF_MAX_DIM,
  parameter int MAX_MEMORIES = dptk_pkg::DEF_MAX_MEMORIES,
  parameter int K_MAX        = dptk_pkg::DEF_K_MAX
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dptk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dptk_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // element
  input  logic [0:0]                          s_tuser,   // mode
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [63:0]                         m_tdata,   // rank, memory_index, score
  output logic [1:0]                          m_tuser,   // found, bank_overflow
  output logic                                m_tlast
);

  logic [dptk_pkg::VLEN_W-1:0]   vector_length;
  logic [dptk_pkg::RCNT_W-1:0]   result_count;
  logic                          q_push, q_pop, q_valid;
  dptk_pkg::entry_t              push_entry, pop_entry;
  logic [dptk_pkg::QUEUE_CW-1:0] q_free;

  logic [dptk_pkg::RANK_W-1:0]         rank;
  logic [dptk_pkg::INDEX_W-1:0]        memory_index;
  logic signed [dptk_pkg::SCORE_W-1:0] score;
  logic                                found, bank_overflow;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= dptk_pkg::VLEN_RESET;
      result_count  <= dptk_pkg::RCNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dptk_pkg::REG_VECTOR_LENGTH: vector_length <= cfg_data;
        dptk_pkg::REG_RESULT_COUNT:  result_count  <= cfg_data[dptk_pkg::RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  dptk_front #(
    .MAX_DIM      (MAX_DIM),
    .MAX_MEMORIES (MAX_MEMORIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_mode       (s_tuser[0]),
    .in_element    (s_tdata),
    .in_bank_end   (s_tlast),
    .vector_length (vector_length),
    .q_free        (q_free),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  dptk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (pop_entry),
    .free     (q_free)
  );

  dptk_back #(
    .K_MAX (K_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .result_count (result_count),
    .q_valid      (q_valid),
    .q_entry      (pop_entry),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_rank     (rank),
    .out_index    (memory_index),
    .out_score    (score),
    .out_found    (found),
    .out_overflow (bank_overflow),
    .out_last     (m_tlast)
  );

  assign m_tdata = {2'b00, score, memory_index, rank};
  assign m_tuser = {bank_overflow, found};

endmodule

>>> hw/rtl/dptk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptk_front
// Accepts query and bank elements, keeps the query store, multiplies and
// accumulates each bank vector, and queues one entry per closed vector.
// ----------------------------------------------------------------------------
module dptk_front #(
  parameter int MAX_DIM      = dptk_pkg::DEF_MAX_DIM,
  parameter int MAX_MEMORIES = dptk_pkg::DEF_MAX_MEMORIES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [dptk_pkg::ELEM_W-1:0]   in_element,
  input  logic                                 in_bank_end,
  input  logic [dptk_pkg::VLEN_W-1:0]          vector_length,
  input  logic [dptk_pkg::QUEUE_CW-1:0]        q_free,
  output logic                                 q_push,
  output dptk_pkg::entry_t                     q_entry
);

  localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW  = $clog2(MAX_DIM + 1);
  localparam int LW1 = LW + 1;
  localparam int VW  = $clog2(MAX_MEMORIES + 1);
  localparam int QCW = dptk_pkg::QUEUE_CW;

  logic signed [dptk_pkg::ELEM_W-1:0] qmem [MAX_DIM];

  logic [LW-1:0] len;
  logic [PW-1:0] qpos;
  logic [PW-1:0] epos;
  logic [VW-1:0] vcount;
  logic          ovf;

  logic v1, c1, v2, c2;
  logic signed [dptk_pkg::ELEM_W-1:0]  elem1, q1;
  logic signed [dptk_pkg::PROD_W-1:0]  prod2;
  dptk_pkg::entry_t                    meta1, meta2;
  logic signed [dptk_pkg::SCORE_W-1:0] running_sum;
  logic signed [dptk_pkg::SCORE_W-1:0] acc;

  logic          accept, acc_q, acc_m;
  logic          qend, eend, close, scored;
  logic [QCW-1:0] pend;

  always_comb begin
    if (vector_length == '0) begin
      len = LW'(1);
    end else if (32'(vector_length) > MAX_DIM) begin
      len = LW'(MAX_DIM);
    end else begin
      len = LW'(vector_length);
    end
  end

  // room for every closing item in flight plus this one
  assign pend     = QCW'(v1 && c1) + QCW'(v2 && c2);
  assign in_ready = q_free > pend;
  assign accept   = in_valid && in_ready;
  assign acc_q    = accept && !in_mode;
  assign acc_m    = accept && in_mode;

  assign qend   = (LW1'(qpos) + LW1'(1)) >= LW1'(len);
  assign eend   = (LW1'(epos) + LW1'(1)) >= LW1'(len);
  assign close  = eend || in_bank_end;
  assign scored = 32'(vcount) < MAX_MEMORIES;

  always_ff @(posedge clk) begin
    if (acc_q) begin
      qmem[qpos] <= in_element;
    end
    if (acc_m) begin
      q1 <= qmem[epos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qpos   <= '0;
      epos   <= '0;
      vcount <= '0;
      ovf    <= 1'b0;
    end else begin
      if (acc_q) begin
        qpos <= qend ? '0 : qpos + PW'(1);
      end
      if (acc_m) begin
        if (in_bank_end) begin
          epos   <= '0;
          vcount <= '0;
          ovf    <= 1'b0;
        end else if (close) begin
          epos <= '0;
          if (scored) begin
            vcount <= vcount + VW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end else begin
          epos <= epos + PW'(1);
        end
      end
    end
  end

  // stage 1: query word read, stage 2: product, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= acc_m;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_m) begin
      elem1          <= in_element;
      c1             <= close;
      meta1.score    <= '0;
      meta1.index    <= dptk_pkg::INDEX_W'(vcount);
      meta1.scored   <= scored;
      meta1.bank_end <= in_bank_end;
      meta1.overflow <= ovf || (close && !scored);
    end
    c2    <= c1;
    meta2 <= meta1;
    prod2 <= elem1 * q1;
  end

  assign acc = running_sum + dptk_pkg::SCORE_W'(prod2);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (v2) begin
      running_sum <= c2 ? '0 : acc;
    end
  end

  assign q_push = v2 && c2;

  always_comb begin
    q_entry       = meta2;
    q_entry.score = acc;
  end

endmodule

>>> hw/rtl/dptk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptk_queue
// Short first-in first-out queue of closed-vector entries.
// ----------------------------------------------------------------------------
module dptk_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dptk_pkg::entry_t              wr_entry,
  input  logic                          pop,
  output logic                          rd_valid,
  output dptk_pkg::entry_t              rd_entry,
  output logic [dptk_pkg::QUEUE_CW-1:0] free
);

  localparam int D   = dptk_pkg::QUEUE_DEPTH;
  localparam int AW  = (D > 1) ? $clog2(D) : 1;
  localparam int CW  = dptk_pkg::QUEUE_CW;

  dptk_pkg::entry_t slots [D];
  logic [AW-1:0]    wp, rp;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign rd_valid = count != '0;
  assign rd_entry = slots[rp];
  assign free     = CW'(D) - count;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (32'(wp) == D - 1) ? '0 : wp + AW'(1);
      end
      if (do_pop) begin
        rp <= (32'(rp) == D - 1) ? '0 : rp + AW'(1);
      end
      count <= count + CW'(push) - CW'(do_pop);
    end
  end

endmodule

>>> hw/rtl/dptk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dptk_back
// Keeps the sorted best-K list, inserts one score per cycle with parallel
// compares while idle, and streams the list out by rank when a bank pass ends.
// ----------------------------------------------------------------------------
module dptk_back #(
  parameter int K_MAX = dptk_pkg::DEF_K_MAX
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [dptk_pkg::RCNT_W-1:0]          result_count,
  input  logic                                 q_valid,
  input  dptk_pkg::entry_t                     q_entry,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dptk_pkg::RANK_W-1:0]          out_rank,
  output logic [dptk_pkg::INDEX_W-1:0]         out_index,
  output logic signed [dptk_pkg::SCORE_W-1:0]  out_score,
  output logic                                 out_found,
  output logic                                 out_overflow,
  output logic                                 out_last
);

  localparam int KCW = $clog2(K_MAX + 1);
  localparam int IW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;

  logic signed [dptk_pkg::SCORE_W-1:0] best_score [K_MAX];
  logic [dptk_pkg::INDEX_W-1:0]        best_index [K_MAX];
  logic [KCW-1:0] filled, k, n, r;
  logic           ovf_hold;
  logic [K_MAX-1:0] ge;
  logic           room, do_insert, load, found, rlast;
  logic [IW-1:0]  ri;

  always_comb begin
    if (result_count == '0) begin
      k = KCW'(1);
    end else if (32'(result_count) > K_MAX) begin
      k = KCW'(K_MAX);
    end else begin
      k = KCW'(result_count);
    end
  end

  assign n = (filled < k) ? filled : k;

  // entries at or above the new score form a prefix of the list
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      ge[i] = (KCW'(i) < n) && (best_score[i] >= q_entry.score);
    end
  end

  assign room      = !ge[IW'(k - KCW'(1))];
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign do_insert = q_pop && q_entry.scored && room;

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (KCW'(i) < k && !ge[i]) begin
          if (i == 0) begin
            best_score[i] <= q_entry.score;
            best_index[i] <= q_entry.index;
          end else if (ge[i-1]) begin
            best_score[i] <= q_entry.score;
            best_index[i] <= q_entry.index;
          end else begin
            best_score[i] <= best_score[i-1];
            best_index[i] <= best_index[i-1];
          end
        end
      end
    end
  end

  assign load  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign ri    = IW'(r);
  assign found = r < n;
  assign rlast = r == (k - KCW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      filled <= '0;
      r      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_entry.scored) begin
              filled <= (n < k) ? n + KCW'(1) : k;
            end
            if (q_entry.bank_end) begin
              state <= ST_EMIT;
              r     <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            if (rlast) begin
              state  <= ST_IDLE;
              filled <= '0;
            end else begin
              r <= r + KCW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_entry.bank_end) begin
      ovf_hold <= q_entry.overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rank     <= dptk_pkg::RANK_W'(r);
      out_found    <= found;
      out_index    <= found ? best_index[ri] : '0;
      out_score    <= found ? best_score[ri] : '0;
      out_overflow <= ovf_hold;
      out_last     <= rlast;
    end
  end

endmodule

>>> dv/tb_dot_product_top_k_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dot_product_top_k_search
// Self-checking bench for the dot-product top-K search block. Query and bank
// elements go in on the slave stream; a built-in scoring and ranking model
// predicts every ranked result, which is checked field by field on the
// master stream. Both sides idle at random, and the receiver holds off once
// for a long stretch. Covered: a bank end at reset sizes, extreme products,
// ties, empty slots, early bank ends, query wrap, and a filled-up queue.
// ----------------------------------------------------------------------------
module tb_dot_product_top_k_search;

  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE      = 16;
  localparam int RAND_ITEMS  = 140;

  typedef struct packed {
    logic                        mode;
    logic [dptk_pkg::ELEM_W-1:0] elem;
    logic                        last;
  } elem_xfer_t;

  typedef struct {
    logic [dptk_pkg::RANK_W-1:0]  rank;
    logic [dptk_pkg::INDEX_W-1:0] index;
    logic [dptk_pkg::SCORE_W-1:0] score;
    logic                         found;
    logic                         overflow;
    logic                         last;
  } hit_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dptk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dptk_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [15:0]                     s_tdata = '0;   // element
  logic [0:0]                      s_tuser = '0;   // mode
  logic                            s_tlast = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [63:0]                     m_tdata;        // rank, memory_index, score
  logic [1:0]                      m_tuser;        // found, bank_overflow
  logic                            m_tlast;

  dot_product_top_k_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #1 clk = ~clk;

  // search model state
  logic [dptk_pkg::VLEN_W-1:0]         cfg_vlen;
  logic [dptk_pkg::RCNT_W-1:0]         cfg_rcnt;
  logic signed [dptk_pkg::ELEM_W-1:0]  query_mem [0:dptk_pkg::DEF_MAX_DIM-1];
  int                                  q_pos;
  int                                  e_pos;
  logic signed [dptk_pkg::SCORE_W-1:0] acc;
  int                                  vec_cnt;
  int                                  n_kept;
  logic signed [dptk_pkg::SCORE_W-1:0] top_score [0:dptk_pkg::DEF_K_MAX-1];
  logic [dptk_pkg::INDEX_W-1:0]        top_index [0:dptk_pkg::DEF_K_MAX-1];
  bit                                  ovf_seen;

  elem_xfer_t element_q[$];
  hit_t       expected_hits[$];

  // stimulus side bookkeeping
  int         gen_qpos = 0;
  int         queued_items = 0;
  bit         noisy = 1'b0;
  int         tx_wait = 0;
  int         tx_calm = 0;
  int         rx_stall = 0;
  int         rx_calm = 0;
  int         rx_hold_left = 0;
  int         errors = 0;
  int         stuck_cycles = 0;
  elem_xfer_t tx_item;
  logic [15:0] tie_vec [0:2];

  function automatic int vec_len();
    if (cfg_vlen == 0) return 1;
    if (cfg_vlen > dptk_pkg::DEF_MAX_DIM) return dptk_pkg::DEF_MAX_DIM;
    return int'(cfg_vlen);
  endfunction

  function automatic int keep_k();
    if (cfg_rcnt == 0) return 1;
    if (cfg_rcnt > dptk_pkg::DEF_K_MAX) return dptk_pkg::DEF_K_MAX;
    return int'(cfg_rcnt);
  endfunction

  // sorted insert; an equal score goes below the one already held
  function automatic void insert_top(logic signed [dptk_pkg::SCORE_W-1:0] s, int idx);
    int k;
    int n;
    int p;
    int i;
    k = keep_k();
    n = (n_kept < k) ? n_kept : k;
    p = 0;
    while (p < n && !(s > top_score[p])) p++;
    if (p >= k) begin
      n_kept = n;
      return;
    end
    i = (n < k) ? n : k - 1;
    while (i > p) begin
      top_score[i] = top_score[i-1];
      top_index[i] = top_index[i-1];
      i--;
    end
    top_score[p] = s;
    top_index[p] = dptk_pkg::INDEX_W'(idx);
    n_kept = (n < k) ? n + 1 : k;
  endfunction

  function automatic void predict_search(logic mode,
                                         logic signed [dptk_pkg::ELEM_W-1:0] elem,
                                         logic bank_end);
    int     len;
    int     k;
    int     n;
    longint prod;
    hit_t   h;
    len = vec_len();
    if (!mode) begin
      if (q_pos < dptk_pkg::DEF_MAX_DIM) query_mem[q_pos] = elem;
      q_pos = (q_pos + 1 >= len) ? 0 : q_pos + 1;
      return;
    end
    prod = longint'(query_mem[e_pos]) * longint'(elem);
    acc  = acc + dptk_pkg::SCORE_W'(prod);
    if (e_pos + 1 >= len || bank_end) begin
      if (vec_cnt < dptk_pkg::DEF_MAX_MEMORIES) begin
        insert_top(acc, vec_cnt);
        vec_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
      acc   = '0;
      e_pos = 0;
    end else begin
      e_pos++;
    end
    if (!bank_end) return;
    k = keep_k();
    n = (n_kept < k) ? n_kept : k;
    for (int r = 0; r < k; r++) begin
      h.rank     = dptk_pkg::RANK_W'(r);
      h.found    = (r < n);
      h.index    = (r < n) ? top_index[r] : '0;
      h.score    = (r < n) ? top_score[r] : '0;
      h.overflow = ovf_seen;
      h.last     = (r + 1 == k);
      expected_hits.push_back(h);
    end
    vec_cnt  = 0;
    n_kept   = 0;
    ovf_seen = 1'b0;
    acc      = '0;
    e_pos    = 0;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    // small values make equal scores likely
    if (r < 40) return 16'(int'($urandom_range(0, 8)) - 4);
    return 16'($urandom());
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic check_hit();
    hit_t want;
    if (expected_hits.size() == 0) begin
      note_error($sformatf("result with none pending: rank %0d index %0d score %0d",
                           m_tdata[3:0], m_tdata[19:4], $signed(m_tdata[61:20])));
      return;
    end
    want = expected_hits.pop_front();
    if (m_tdata[3:0] !== want.rank || m_tdata[19:4] !== want.index ||
        m_tdata[61:20] !== want.score || m_tdata[63:62] !== 2'b00 ||
        m_tuser[0] !== want.found || m_tuser[1] !== want.overflow ||
        m_tlast !== want.last) begin
      note_error($sformatf({"exp rank %0d idx %0d score %0d found %0b ovf %0b last %0b; ",
                            "got rank %0d idx %0d score %0d found %0b ovf %0b last %0b pad %b"},
                           want.rank, want.index, $signed(want.score), want.found,
                           want.overflow, want.last, m_tdata[3:0], m_tdata[19:4],
                           $signed(m_tdata[61:20]), m_tuser[0], m_tuser[1], m_tlast,
                           m_tdata[63:62]));
    end
  endtask

  // element driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_search(s_tuser[0], s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_tvalid <= 1'b0;
        end else if (element_q.size() > 0) begin
          tx_item = element_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= tx_item.elem;
          s_tuser  <= tx_item.mode;
          s_tlast  <= tx_item.last;
          tx_wait  = pick_gap(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_hit();
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  // long receiver hold-off, armed from the sequence
  always @(posedge clk) begin
    if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_dot_product_top_k_search: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic push_query(input logic [15:0] v, input bit tl);
    elem_xfer_t x;
    x.mode = 1'b0;
    x.elem = v;
    x.last = tl;
    element_q.push_back(x);
    queued_items++;
    gen_qpos = (gen_qpos + 1 >= vec_len()) ? 0 : gen_qpos + 1;
  endtask

  task automatic push_mem(input logic [15:0] v, input bit tl);
    elem_xfer_t x;
    x.mode = 1'b1;
    x.elem = v;
    x.last = tl;
    element_q.push_back(x);
    queued_items++;
  endtask

  // writes every query entry below L and leaves the write pointer at zero;
  // a write pointer left past a shorter L only wraps and is not counted
  task automatic load_query(input bit fixed, input logic [15:0] v);
    int cnt;
    cnt = 0;
    do begin
      if (gen_qpos < vec_len()) cnt++;
      push_query(fixed ? v : rand_elem(), 1'b0);
    end while (cnt < vec_len() || gen_qpos != 0);
  endtask

  task automatic push_vector(input int cut, input bit close_bank);
    for (int j = 0; j < cut; j++) begin
      if (noisy && $urandom_range(0, 99) < 4) push_query(rand_elem(), $urandom_range(0, 1));
      push_mem(rand_elem(), close_bank && j == cut - 1);
    end
  endtask

  task automatic run_bank(input int nvec, input bit early);
    for (int i = 0; i < nvec; i++) begin
      push_vector((i == nvec - 1 && early) ? $urandom_range(1, vec_len()) : vec_len(),
                  i == nvec - 1);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (element_q.size() != 0 || s_tvalid || expected_hits.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dptk_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dptk_pkg::CFG_DATA_W'(val);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dptk_pkg::REG_VECTOR_LENGTH) cfg_vlen = dptk_pkg::VLEN_W'(val);
    else if (idx == dptk_pkg::REG_RESULT_COUNT) cfg_rcnt = dptk_pkg::RCNT_W'(val);
  endtask

  task automatic configure(input int vl, input int rc);
    write_reg(dptk_pkg::REG_VECTOR_LENGTH, vl);
    write_reg(dptk_pkg::REG_RESULT_COUNT, rc);
    @(negedge clk);
  endtask

  task automatic random_phase();
    int r;
    int vl;
    r = $urandom_range(0, 99);
    if (r < 10) vl = 0;
    else if (r < 65) vl = $urandom_range(1, 6);
    else if (r < 90) vl = $urandom_range(7, 20);
    else vl = $urandom_range(21, 32);
    configure(vl, $urandom_range(0, 31));
    load_query(1'b0, '0);
    noisy = 1'b1;
    repeat ($urandom_range(1, 2)) run_bank($urandom_range(1, 4), $urandom_range(0, 3) == 0);
    noisy = 1'b0;
    wait_idle();
  endtask

  initial begin
    int base;
    cfg_vlen = dptk_pkg::VLEN_RESET;
    cfg_rcnt = dptk_pkg::RCNT_RESET;
    q_pos    = 0;
    e_pos    = 0;
    acc      = '0;
    vec_cnt  = 0;
    n_kept   = 0;
    ovf_seen = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes: two query entries, then a bank end two elements in
    push_query(rand_elem(), 1'b0);
    push_query(rand_elem(), 1'b0);
    push_vector(2, 1'b1);
    wait_idle();

    // length and count written as zero; extreme products
    configure(0, 0);
    load_query(1'b1, 16'h8000);
    push_mem(16'h7FFF, 1'b0);
    push_mem(16'h8000, 1'b0);
    push_mem(16'h0000, 1'b0);
    push_mem(16'hFFFF, 1'b0);
    push_mem(16'h0001, 1'b1);
    wait_idle();

    // query wrap, equal scores, tlast on a query element, early end, empty slots
    configure(3, 31);
    repeat (4) push_query(rand_elem(), 1'b0);
    load_query(1'b0, '0);
    for (int j = 0; j < 3; j++) tie_vec[j] = rand_elem();
    repeat (2) for (int j = 0; j < 3; j++) push_mem(tie_vec[j], 1'b0);
    push_query(rand_elem(), 1'b1);
    push_vector(3, 1'b0);
    push_vector(2, 1'b1);
    wait_idle();

    // receiver holds off while many short banks pile up behind it
    configure(1, 16);
    load_query(1'b0, '0);
    rx_hold_left = 400;
    repeat (12) run_bank($urandom_range(2, 4), 1'b0);
    wait_idle();

    base = queued_items;
    while (queued_items - base < RAND_ITEMS) random_phase();

    if (errors == 0) begin
      $display("tb_dot_product_top_k_search: PASS");
    end else begin
      $display("tb_dot_product_top_k_search: FAIL");
    end
    $finish;
  end

endmodule
